// ===== src/wnm_pkg.sv =====
`timescale 1ns / 1ps

package wnm_pkg;

  // input beat kinds, carried in in_tuser
  typedef enum logic [1:0] {
    OP_APPEND_PAT  = 2'd0,
    OP_APPEND_NAME = 2'd1,
    OP_EVALUATE    = 2'd2,
    OP_CLEAR_PAT   = 2'd3
  } opcode_t;

  // 9-bit character codes: bit 8 marks a position past the end of a string
  localparam logic [8:0] STAR_CHAR  = 9'h02A;
  localparam logic [8:0] QMARK_CHAR = 9'h03F;
  localparam logic [8:0] END_MARK   = 9'h100;

  // fold a-z to upper case unless the compare is case sensitive
  function automatic logic [8:0] char_code(input logic [7:0] c, input logic past_end,
                                           input logic case_sens);
    logic [8:0] code;
    code = {1'b0, c};
    if (!case_sens && c >= 8'h61 && c <= 8'h7A) begin
      code = {1'b0, c - 8'h20};
    end
    if (past_end) begin
      code = END_MARK;
    end
    return code;
  endfunction

endpackage

// ===== src/wildcard_name_match_core.sv =====
`timescale 1ns / 1ps

// channel  | ports                      | beat contents (low bit up)
// ---------+----------------------------+--------------------------------------------
// input    | in_tvalid/in_tready        | tdata: char_value[7:0]; tuser: opcode[1:0]
// result   | out_tvalid/out_tready      | tdata: matched, status, zero pad to 8 bits
// config   | cfg_wr_en/cfg_wr_data      | case_sensitive
//
// append and clear beats leave the core idle; one beat is accepted per cycle while in_tready is high.
// an evaluate beat holds in_tready low while the matcher walks the two stores:
// each compare step is a store read (S_RD), then a compare (S_CMP), as each
// store has a single registered read port.
// an evaluate with a pending overflow goes straight to the result state with no walk.
// rst_n is synchronous, active low; it clears lengths, overflow, config and handshakes.
// a result waiting on out_tready does not block append beats; only the next
// evaluate waits for the output register to drain.

module wildcard_name_match_core #(
  parameter int MAX_LEN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  // cfg
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,   // case_sensitive
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // char_value[7:0]
  input  logic [1:0] in_tuser,      // opcode[1:0]
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata      // [0] matched, [1] status, [7:2] zero
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int CW = $clog2(MAX_LEN + 2);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_CMP, S_DONE} state_t;
  typedef enum logic [1:0] {PH_LEAD, PH_REM, PH_TAIL} phase_t;

  state_t  state_r;
  phase_t  phase_r;

  logic          cs_r;
  logic [LW-1:0] p_len_r, p_eff_r, n_len_r, n_eff_r;
  logic          ovf_r;
  logic [CW-1:0] w_r, s_r, back_w_r, back_s_r;
  logic          match_r, status_r;
  logic          out_valid_r;
  logic          res_match_r, res_status_r;

  logic [7:0]    pat_mem [MAX_LEN];
  logic [7:0]    nam_mem [MAX_LEN];
  logic [7:0]    pat_rd_r, nam_rd_r;

  logic          in_fire, pat_we, nam_we;
  logic          pat_full, nam_full;
  logic [CW-1:0] plen, nlen, w_inc, s_inc;
  logic [8:0]    wc, sc;
  logic          chars_eq, out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign pat_full   = (p_len_r == LW'(MAX_LEN));
  assign nam_full   = (n_len_r == LW'(MAX_LEN));
  assign pat_we     = in_fire && (in_tuser == wnm_pkg::OP_APPEND_PAT) && !pat_full;
  assign nam_we     = in_fire && (in_tuser == wnm_pkg::OP_APPEND_NAME) && !nam_full;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_status_r, res_match_r};
  assign out_free   = !out_valid_r || out_tready;

  // current characters of the walk, end mark past each effective length
  assign plen     = CW'(p_eff_r);
  assign nlen     = CW'(n_eff_r);
  assign w_inc    = w_r + CW'(1);
  assign s_inc    = s_r + CW'(1);
  assign wc       = wnm_pkg::char_code(pat_rd_r, w_r >= plen, cs_r);
  assign sc       = wnm_pkg::char_code(nam_rd_r, s_r >= nlen, cs_r);
  assign chars_eq = (wc == sc) || (wc == wnm_pkg::QMARK_CHAR);

  // pattern and name stores, one write and one registered read each
  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[p_len_r[AW-1:0]] <= in_tdata;
    end
    pat_rd_r <= pat_mem[w_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (nam_we) begin
      nam_mem[n_len_r[AW-1:0]] <= in_tdata;
    end
    nam_rd_r <= nam_mem[s_r[AW-1:0]];
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r <= 1'b0;
    end else if (cfg_wr_en) begin
      cs_r <= cfg_wr_data;
    end
  end

  // sequencer: appends, match walk and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_LEAD;
      p_len_r      <= '0;
      p_eff_r      <= '0;
      n_len_r      <= '0;
      n_eff_r      <= '0;
      ovf_r        <= 1'b0;
      w_r          <= '0;
      s_r          <= '0;
      back_w_r     <= '0;
      back_s_r     <= '0;
      match_r      <= 1'b0;
      status_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      res_match_r  <= 1'b0;
      res_status_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_tuser)
              wnm_pkg::OP_APPEND_PAT: begin
                if (pat_full) begin
                  ovf_r <= 1'b1;
                end else begin
                  p_len_r <= p_len_r + LW'(1);
                  // effective length stops at the first zero byte
                  if (p_eff_r == p_len_r && in_tdata != 8'd0) begin
                    p_eff_r <= p_eff_r + LW'(1);
                  end
                end
              end
              wnm_pkg::OP_APPEND_NAME: begin
                if (nam_full) begin
                  ovf_r <= 1'b1;
                end else begin
                  n_len_r <= n_len_r + LW'(1);
                  if (n_eff_r == n_len_r && in_tdata != 8'd0) begin
                    n_eff_r <= n_eff_r + LW'(1);
                  end
                end
              end
              wnm_pkg::OP_EVALUATE: begin
                if (ovf_r) begin
                  ovf_r    <= 1'b0;
                  match_r  <= 1'b0;
                  status_r <= 1'b1;
                  state_r  <= S_DONE;
                end else begin
                  status_r <= 1'b0;
                  w_r      <= '0;
                  s_r      <= '0;
                  back_w_r <= '0;
                  back_s_r <= '0;
                  phase_r  <= PH_LEAD;
                  state_r  <= S_RD;
                end
              end
              default: begin
                p_len_r <= '0;
                p_eff_r <= '0;
              end
            endcase
          end
        end
        S_RD: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          unique case (phase_r)
            // leading part up to the first star
            PH_LEAD: begin
              if (s_r >= nlen) begin
                phase_r <= PH_TAIL;
              end else if (wc == wnm_pkg::STAR_CHAR) begin
                phase_r <= PH_REM;
              end else if (!chars_eq) begin
                match_r <= 1'b0;
                state_r <= S_DONE;
              end else begin
                w_r     <= w_inc;
                s_r     <= s_inc;
                state_r <= S_RD;
              end
            end
            // remainder with backtrack to the last star
            PH_REM: begin
              if (s_r >= nlen) begin
                phase_r <= PH_TAIL;
              end else if (wc == wnm_pkg::STAR_CHAR) begin
                w_r <= w_inc;
                if (w_inc >= plen) begin
                  match_r <= 1'b1;
                  state_r <= S_DONE;
                end else begin
                  back_w_r <= w_inc;
                  back_s_r <= s_inc;
                  state_r  <= S_RD;
                end
              end else if (chars_eq) begin
                w_r     <= w_inc;
                s_r     <= s_inc;
                state_r <= S_RD;
              end else begin
                w_r      <= back_w_r;
                s_r      <= back_s_r;
                back_s_r <= back_s_r + CW'(1);
                state_r  <= S_RD;
              end
            end
            // trailing stars only
            default: begin
              if (wc == wnm_pkg::STAR_CHAR) begin
                w_r     <= w_inc;
                state_r <= S_RD;
              end else begin
                match_r <= (w_r >= plen);
                state_r <= S_DONE;
              end
            end
          endcase
        end
        default: begin
          // hand the result over and clear the name
          if (out_free) begin
            out_valid_r  <= 1'b1;
            res_match_r  <= match_r;
            res_status_r <= status_r;
            n_len_r      <= '0;
            n_eff_r      <= '0;
            state_r      <= S_IDLE;
          end
        end
      endcase
    end
  end

  // effective lengths never pass the stored lengths
  a_eff_len: assert property (@(posedge clk) disable iff (!rst_n)
    (p_eff_r <= p_len_r) && (n_eff_r <= n_len_r))
    else $error("effective length beyond stored length");

  // pattern index never passes the pattern length during the walk
  a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_CMP) |-> (w_r <= plen))
    else $error("pattern index out of range");

  // name index and backtrack point stay bounded
  a_s_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_CMP) |-> (s_r <= nlen && back_s_r <= nlen + CW'(1)))
    else $error("name index out of range");

  // an overflow report never claims a match
  a_ovf_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_match_r && res_status_r))
    else $error("overflow result reports a match");

  // an evaluate beat stops intake on the next cycle
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == wnm_pkg::OP_EVALUATE) |=> !in_tready)
    else $error("intake open during evaluation");

endmodule
